// ----- sv/tasr_pkg.sv -----
`timescale 1ns / 1ps
// tasr_pkg: widths, codes, payload types and clamp helpers for the two-axis servo ramp
// no dependencies; used by the channel interfaces, the serial ratio unit and the top level

package tasr_pkg;

   // angle width and derived widths
   localparam int ANGLE_W = 8;
   localparam int DELTA_W = ANGLE_W + 1;
   localparam int PROD_W  = 2 * ANGLE_W;
   localparam int CNT_W   = $clog2(PROD_W);
   localparam logic [ANGLE_W-1:0] MAX_ANGLE_RESET = ANGLE_W'(180);

   // operation codes
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_MOVE    = 2'd1,
      OP_ENABLE  = 2'd2,
      OP_DISABLE = 2'd3
   } op_type;

   // status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DISABLED = 2'd1,
      ST_BUSY     = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [ANGLE_W-1:0] target_a;
      logic [ANGLE_W-1:0] target_b;
   } req_payload_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle_a;
      logic [ANGLE_W-1:0] angle_b;
      logic               write_a;
      logic               write_b;
      logic               busy_res;
      logic               move_done;
      logic [1:0]         status;
   } rsp_payload_type;

   // clamp an angle to 0..lim
   function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] v,
                                                      input logic [ANGLE_W-1:0] lim);
      return (v > lim) ? lim : v;
   endfunction

   // magnitude of a signed delta; never exceeds the angle range
   function automatic logic [ANGLE_W-1:0] delta_mag(input logic [DELTA_W-1:0] d);
      logic [DELTA_W-1:0] m;
      m = d[DELTA_W-1] ? (~d + DELTA_W'(1)) : d;
      return m[ANGLE_W-1:0];
   endfunction

   // start plus or minus the scaled step, floored at zero and clamped to lim
   function automatic logic [ANGLE_W-1:0] ramp_value(input logic [ANGLE_W-1:0] start,
                                                     input logic               neg,
                                                     input logic [ANGLE_W-1:0] q,
                                                     input logic [ANGLE_W-1:0] lim);
      logic [ANGLE_W:0] sum;
      logic [ANGLE_W:0] lim_x;
      sum   = neg ? ({1'b0, start} - {1'b0, q}) : ({1'b0, start} + {1'b0, q});
      lim_x = {1'b0, lim};
      if (neg && (q > start)) begin
         return '0;
      end else if (sum > lim_x) begin
         return lim;
      end else begin
         return sum[ANGLE_W-1:0];
      end
   endfunction

endpackage

// ----- sv/tasr_req_if.sv -----
`timescale 1ns / 1ps
// tasr_req_if: request channel (valid, ready, payload) for the servo ramp
// depends on tasr_pkg for the payload type

interface tasr_req_if;
   import tasr_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/tasr_rsp_if.sv -----
`timescale 1ns / 1ps
// tasr_rsp_if: response channel (valid, ready, payload) for the servo ramp
// depends on tasr_pkg for the payload type

interface tasr_rsp_if;
   import tasr_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/tasr_serial_ratio.sv -----
`timescale 1ns / 1ps
// tasr_serial_ratio: bit-serial mag*step/total, shift-add multiply then restoring divide
// depends on tasr_pkg for widths

module tasr_serial_ratio (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tasr_pkg::ANGLE_W-1:0] mag,
   input  logic [tasr_pkg::ANGLE_W-1:0] step,
   input  logic [tasr_pkg::ANGLE_W-1:0] total,
   output logic                         done,
   output logic [tasr_pkg::ANGLE_W-1:0] quotient
);
   import tasr_pkg::*;

   typedef enum logic [1:0] {
      U_IDLE,
      U_MUL,
      U_DIV
   } unit_state_type;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(ANGLE_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

   unit_state_type     state_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  mcand_ff;
   logic [ANGLE_W-1:0] mplier_ff;
   logic [ANGLE_W-1:0] divisor_ff;
   logic [ANGLE_W:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]  dvd_ff, dvd_in;
   logic               done_ff;
   logic [ANGLE_W:0]   rem_shift;

   // one multiply bit: add the shifted multiplicand when the multiplier bit is set
   always_comb begin
      prod_in = mplier_ff[0] ? (prod_ff + mcand_ff) : prod_ff;
   end

   // one divide bit: shift in the next dividend bit, subtract when it fits
   always_comb begin
      rem_shift = {rem_ff[ANGLE_W-1:0], dvd_ff[PROD_W-1]};
      if (rem_shift >= {1'b0, divisor_ff}) begin
         rem_in = rem_shift - {1'b0, divisor_ff};
         dvd_in = {dvd_ff[PROD_W-2:0], 1'b1};
      end else begin
         rem_in = rem_shift;
         dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
      end
   end

   // sequencer and data path registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            U_IDLE: begin
               if (start) begin
                  prod_ff    <= '0;
                  mcand_ff   <= {{ANGLE_W{1'b0}}, mag};
                  mplier_ff  <= step;
                  divisor_ff <= total;
                  count_ff   <= '0;
                  state_ff   <= U_MUL;
               end
            end
            U_MUL: begin
               prod_ff   <= prod_in;
               mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[ANGLE_W-1:1]};
               if (count_ff == MUL_LAST) begin
                  rem_ff   <= '0;
                  dvd_ff   <= prod_in;
                  count_ff <= '0;
                  state_ff <= U_DIV;
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            U_DIV: begin
               rem_ff <= rem_in;
               dvd_ff <= dvd_in;
               if (count_ff == DIV_LAST) begin
                  done_ff  <= 1'b1;
                  state_ff <= U_IDLE;
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            default: begin
               state_ff <= U_IDLE;
            end
         endcase
      end
   end

   // step never exceeds total, so the quotient fits the angle width
   assign done     = done_ff;
   assign quotient = dvd_ff[ANGLE_W-1:0];

endmodule

// ----- sv/two_axis_servo_ramp_top.sv -----
`timescale 1ns / 1ps
// two_axis_servo_ramp_top: coordinated two-axis servo ramp with enable, disable and move
// depends on tasr_pkg, tasr_req_if, tasr_rsp_if and tasr_serial_ratio
//
//   channel    direction  handshake              contents
//   req_chan   in         valid/ready            operation, target_a, target_b
//   rsp_chan   out        valid/ready            angles, strobes, busy, done, status
//   csr_*      in         csr_we                 max_angle
//
// a tick during a move takes the request, then runs 8 serial multiply bits and 16
// restoring divide bits in the ratio units, then sees both units finish and updates
// the state. every other request is taken and then updates the state directly.
// a new request is taken while the last response is still waiting; the update step
// waits until the response register is free.
// reset returns both axes to angle zero, disabled, with max_angle at 180.

module two_axis_servo_ramp_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [tasr_pkg::ANGLE_W-1:0] csr_wdata,
   tasr_req_if.sink                     req_chan,
   tasr_rsp_if.source                   rsp_chan
);
   import tasr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [ANGLE_W-1:0] ta_ff, ta_in, tb_ff, tb_in;
   logic [ANGLE_W-1:0] max_angle_ff, max_angle_in;
   logic [ANGLE_W-1:0] cur_a_ff, cur_a_in, cur_b_ff, cur_b_in;
   logic [ANGLE_W-1:0] start_a_ff, start_a_in, start_b_ff, start_b_in;
   logic [DELTA_W-1:0] delta_a_ff, delta_a_in, delta_b_ff, delta_b_in;
   logic [ANGLE_W-1:0] total_ff, total_in, index_ff, index_in;
   logic               moving_ff, moving_in, enabled_ff, enabled_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               unit_start;
   logic               done_a, done_b;
   logic [ANGLE_W-1:0] quo_a, quo_b;
   logic               out_free;

   assign accept     = req_chan.valid && req_chan.ready;
   assign unit_start = accept && (req_chan.data.operation == OP_TICK) && moving_ff;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   // per-axis serial ratio units
   tasr_serial_ratio u_ratio_a (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .mag      (delta_mag(delta_a_ff)),
      .step     (index_ff + ANGLE_W'(1)),
      .total    (total_ff),
      .done     (done_a),
      .quotient (quo_a)
   );

   tasr_serial_ratio u_ratio_b (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .mag      (delta_mag(delta_b_ff)),
      .step     (index_ff + ANGLE_W'(1)),
      .total    (total_ff),
      .done     (done_b),
      .quotient (quo_b)
   );

   // next state and update of the axis state
   always_comb begin
      logic [ANGLE_W-1:0] na, nb, ca, cb, tca, tcb, ma, mb;
      logic [DELTA_W-1:0] da, db;

      state_in     = state_ff;
      op_in        = op_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      max_angle_in = csr_we ? csr_wdata : max_angle_ff;
      cur_a_in     = cur_a_ff;
      cur_b_in     = cur_b_ff;
      start_a_in   = start_a_ff;
      start_b_in   = start_b_ff;
      delta_a_in   = delta_a_ff;
      delta_b_in   = delta_b_ff;
      total_in     = total_ff;
      index_in     = index_ff;
      moving_in    = moving_ff;
      enabled_in   = enabled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      na  = ramp_value(start_a_ff, delta_a_ff[DELTA_W-1], quo_a, max_angle_ff);
      nb  = ramp_value(start_b_ff, delta_b_ff[DELTA_W-1], quo_b, max_angle_ff);
      ca  = clamp_angle(cur_a_ff, max_angle_ff);
      cb  = clamp_angle(cur_b_ff, max_angle_ff);
      tca = clamp_angle(ta_ff, max_angle_ff);
      tcb = clamp_angle(tb_ff, max_angle_ff);
      da  = {1'b0, tca} - {1'b0, ca};
      db  = {1'b0, tcb} - {1'b0, cb};
      ma  = delta_mag(da);
      mb  = delta_mag(db);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_chan.data.operation;
               ta_in = req_chan.data.target_a;
               tb_in = req_chan.data.target_b;
               if (unit_start) begin
                  index_in = index_ff + ANGLE_W'(1);
                  state_in = S_CALC;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_CALC: begin
            if (done_a && done_b) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_data_in.write_a   = 1'b0;
               rsp_data_in.write_b   = 1'b0;
               rsp_data_in.move_done = 1'b0;
               rsp_data_in.status    = ST_OK;
               case (op_ff)
                  OP_TICK: begin
                     if (moving_ff) begin
                        cur_a_in              = na;
                        cur_b_in              = nb;
                        rsp_data_in.write_a   = (na != cur_a_ff);
                        rsp_data_in.write_b   = (nb != cur_b_ff);
                        if (index_ff >= total_ff) begin
                           moving_in             = 1'b0;
                           rsp_data_in.move_done = 1'b1;
                        end
                     end
                  end
                  OP_MOVE: begin
                     if (!enabled_ff) begin
                        rsp_data_in.status = ST_DISABLED;
                     end else if (moving_ff) begin
                        rsp_data_in.status = ST_BUSY;
                     end else begin
                        cur_a_in   = ca;
                        cur_b_in   = cb;
                        start_a_in = ca;
                        start_b_in = cb;
                        delta_a_in = da;
                        delta_b_in = db;
                        total_in   = (ma > mb) ? ma : mb;
                        index_in   = '0;
                        moving_in  = (ma != '0) || (mb != '0);
                     end
                  end
                  OP_ENABLE: begin
                     cur_a_in            = tca;
                     cur_b_in            = tcb;
                     rsp_data_in.write_a = 1'b1;
                     rsp_data_in.write_b = 1'b1;
                     enabled_in          = 1'b1;
                     moving_in           = 1'b0;
                  end
                  default: begin
                     enabled_in = 1'b0;
                     moving_in  = 1'b0;
                  end
               endcase
               rsp_data_in.angle_a  = cur_a_in;
               rsp_data_in.angle_b  = cur_b_in;
               rsp_data_in.busy_res = moving_in;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, axis registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_angle_ff <= MAX_ANGLE_RESET;
         cur_a_ff     <= '0;
         cur_b_ff     <= '0;
         start_a_ff   <= '0;
         start_b_ff   <= '0;
         delta_a_ff   <= '0;
         delta_b_ff   <= '0;
         total_ff     <= '0;
         index_ff     <= '0;
         moving_ff    <= 1'b0;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_angle_ff <= max_angle_in;
         cur_a_ff     <= cur_a_in;
         cur_b_ff     <= cur_b_in;
         start_a_ff   <= start_a_in;
         start_b_ff   <= start_b_in;
         delta_a_ff   <= delta_a_in;
         delta_b_ff   <= delta_b_in;
         total_ff     <= total_in;
         index_ff     <= index_in;
         moving_ff    <= moving_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ta_ff       <= ta_in;
      tb_ff       <= tb_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule
